[hdl/sctl_pkg.sv]
// sctl_pkg: shared types and codes of the sorted countdown timer list
// depends on nothing
`default_nettype none
package sctl_pkg;
	localparam int DEPTH_DEF    = 16;
	localparam int TAG_BITS_DEF = 16;
	localparam int MAX_RESULTS  = 16;

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_TICK   = 3'd1;
	localparam logic [2:0] MODE_DELETE = 3'd2;
	localparam logic [2:0] MODE_SEARCH = 3'd3;
	localparam logic [2:0] MODE_LIST   = 3'd4;

	localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
	localparam logic [2:0] KIND_REJECTED  = 3'd1;
	localparam logic [2:0] KIND_COMPLETED = 3'd2;
	localparam logic [2:0] KIND_DELETED   = 3'd3;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
	localparam logic [2:0] KIND_FOUND     = 3'd5;
	localparam logic [2:0] KIND_LISTED    = 3'd6;
	localparam logic [2:0] KIND_EMPTY     = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] time_value;
		logic [15:0] task_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] tag_out;
		logic [15:0] time_left;
		logic        last;
	} out_item_t;
endpackage
`default_nettype wire

[hdl/sorted_countdown_timer_list.sv]
// sorted_countdown_timer_list: sorted table of countdown tasks kept in ram
// depends on sctl_pkg, sctl_ram
//
//   channel | dir | signals                   | payload
//   in      | in  | in_valid / in_ready       | in_item_t
//   out     | out | out_valid / out_ready     | out_item_t
//
// items that sweep the table read it one entry a cycle through a registered
// ram read, unless a stalled result holds the sweep, compacting or shifting by
// writing one entry behind the read pointer; a rejected add or an empty list
// is answered without reading the table.
// reset clears the entry count and control; ram contents need no clearing.
// a stalled result holds the sweep; results are staged one behind so the last
// one can be marked; one item is worked at a time.
`default_nettype none
module sorted_countdown_timer_list
	import sctl_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int W  = 16 + TAG_BITS;
	localparam int RW = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_PROC  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]          st_q;
	in_item_t            cmd_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       rd_q;
	logic [CW-1:0]       wr_q;
	logic                done_q;
	logic [W-1:0]        carry_q;
	logic                hold_q;
	logic [RW-1:0]       nres_q;
	logic                ov_q;
	out_item_t           ob_q;
	out_item_t           pend_q;
	logic                pv_q;

	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [W-1:0]        wdata, rdata;
	logic [15:0]         e_time, dec;
	logic [TAG_BITS-1:0] e_tag, in_tag;
	logic [CW-1:0]       rd_m1;
	logic                ov_set;
	out_item_t           ob_d;

	sctl_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// the entry being processed is at index rd_q - 1
	logic        proc_ok;
	logic [2:0]  emit_kind;
	logic        emit;
	logic [15:0] emit_tag, emit_time;
	assign proc_ok = (st_q == ST_PROC) && (!ov_q || out_ready);

	assign e_time = rdata[W-1 -: 16];
	assign e_tag  = rdata[TAG_BITS-1:0];
	assign dec    = e_time - 16'd1;
	assign in_tag = in_item.task_tag[TAG_BITS-1:0];
	assign rd_m1  = rd_q - 1'b1;
	// re-read the current entry while the sweep is held
	assign raddr  = (st_q == ST_PROC && !proc_ok) ? rd_m1[AW-1:0] : rd_q[AW-1:0];
	assign in_ready  = (st_q == ST_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_item  = ob_q;

	function automatic logic [15:0] tag16(input logic [TAG_BITS-1:0] t);
		return 16'(t);
	endfunction

	always_comb begin
		we = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata;
		emit = 1'b0;
		emit_kind = KIND_LISTED;
		emit_tag = 16'd0;
		emit_time = 16'd0;
		if (proc_ok) begin
			case (cmd_q.mode)
				MODE_ADD: begin
					we = 1'b1;
					if (hold_q) begin
						wdata = carry_q;
					end else if (e_time < cmd_q.time_value) begin
						wdata = rdata;
					end else begin
						wdata = {cmd_q.time_value, cmd_q.task_tag[TAG_BITS-1:0]};
					end
				end
				MODE_TICK: begin
					if (dec == 16'd0) begin
						emit = nres_q < RW'(MAX_RESULTS);
						emit_kind = KIND_COMPLETED;
						emit_tag = tag16(e_tag);
					end else begin
						we = 1'b1;
						wdata = {dec, e_tag};
					end
				end
				MODE_DELETE: begin
					if (done_q) begin
						we = 1'b1;
					end else if (e_time == cmd_q.time_value) begin
						emit = 1'b1;
						emit_kind = KIND_DELETED;
						emit_tag = tag16(e_tag);
						emit_time = cmd_q.time_value;
					end else begin
						we = 1'b1;
					end
				end
				MODE_SEARCH: begin
					if (!done_q && e_time == cmd_q.time_value) begin
						emit = 1'b1;
						emit_kind = KIND_FOUND;
						emit_tag = tag16(e_tag);
						emit_time = cmd_q.time_value;
					end
				end
				default: begin
					emit = nres_q < RW'(MAX_RESULTS);
					emit_kind = KIND_LISTED;
					emit_tag = tag16(e_tag);
					emit_time = e_time;
				end
			endcase
		end else if (st_q == ST_FIN && cmd_q.mode == MODE_ADD) begin
			we = 1'b1;
			wdata = hold_q ? carry_q
				: {cmd_q.time_value, cmd_q.task_tag[TAG_BITS-1:0]};
		end
	end

	// next result presented on the output register
	always_comb begin
		ov_set = 1'b0;
		ob_d = ob_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					if (in_item.mode == MODE_ADD
						&& (in_item.time_value == 16'd0 || cnt_q == CW'(DEPTH))) begin
						ov_set = 1'b1;
						ob_d = '{KIND_REJECTED, 16'(in_tag), in_item.time_value, 1'b1};
					end else if (in_item.mode == MODE_LIST && cnt_q == '0) begin
						ov_set = 1'b1;
						ob_d = '{KIND_EMPTY, 16'd0, 16'd0, 1'b1};
					end
				end
			end
			ST_PROC: begin
				if (emit && pv_q) begin
					ov_set = 1'b1;
					ob_d = pend_q;
				end
			end
			ST_FIN: begin
				if (!ov_q || out_ready) begin
					if (cmd_q.mode == MODE_ADD) begin
						ov_set = 1'b1;
						ob_d = '{KIND_ACCEPTED, cmd_q.task_tag, cmd_q.time_value, 1'b1};
					end else if (pv_q) begin
						ov_set = 1'b1;
						ob_d = '{pend_q.kind, pend_q.tag_out, pend_q.time_left, 1'b1};
					end else if (cmd_q.mode inside {MODE_DELETE, MODE_SEARCH}) begin
						ov_set = 1'b1;
						ob_d = '{KIND_NOT_FOUND, 16'd0, cmd_q.time_value, 1'b1};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			ov_q <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			done_q <= 1'b0;
			hold_q <= 1'b0;
			nres_q <= '0;
			pv_q <= 1'b0;
		end else begin
			if (ov_set) begin
				ov_q <= 1'b1;
				ob_q <= ob_d;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= '{in_item.mode, in_item.time_value, 16'(in_tag)};
						rd_q <= '0;
						wr_q <= '0;
						done_q <= 1'b0;
						hold_q <= 1'b0;
						nres_q <= '0;
						pv_q <= 1'b0;
						case (in_item.mode)
							MODE_ADD: begin
								if (in_item.time_value != 16'd0 && cnt_q != CW'(DEPTH)) begin
									st_q <= (cnt_q == '0) ? ST_FIN : ST_READ;
								end
							end
							MODE_TICK, MODE_DELETE, MODE_SEARCH: begin
								st_q <= (cnt_q == '0) ? ST_FIN : ST_READ;
							end
							MODE_LIST: begin
								if (cnt_q != '0) begin
									st_q <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					rd_q <= rd_q + 1'b1;
					st_q <= ST_PROC;
				end
				ST_PROC: begin
					if (proc_ok) begin
						if (we) begin
							wr_q <= wr_q + 1'b1;
						end
						if (cmd_q.mode == MODE_ADD && !hold_q
							&& !(e_time < cmd_q.time_value)) begin
							hold_q <= 1'b1;
							carry_q <= rdata;
						end else if (cmd_q.mode == MODE_ADD && hold_q) begin
							carry_q <= rdata;
						end
						if (emit) begin
							pend_q <= '{emit_kind, emit_tag, emit_time, 1'b0};
							pv_q <= 1'b1;
							nres_q <= nres_q + 1'b1;
						end
						if (emit && (cmd_q.mode inside {MODE_DELETE, MODE_SEARCH})) begin
							done_q <= 1'b1;
						end
						if (rd_q == cnt_q) begin
							st_q <= ST_FIN;
						end else begin
							rd_q <= rd_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (!ov_q || out_ready) begin
						st_q <= ST_DRAIN;
						case (cmd_q.mode)
							MODE_ADD: begin
								cnt_q <= cnt_q + 1'b1;
							end
							MODE_TICK: begin
								cnt_q <= wr_q;
							end
							MODE_DELETE: begin
								if (done_q) begin
									cnt_q <= cnt_q - 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				default: begin
					if (!ov_q) begin
						st_q <= ST_IDLE;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/sctl_ram.sv]
// sctl_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing
`default_nettype none
module sctl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hdl/sctl_checker.sv]
// sctl_checker: port-level assertions for the sorted countdown timer list
// depends on sctl_pkg, sorted_countdown_timer_list
`default_nettype none
module sctl_checker
	import sctl_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_item,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.kind == KIND_REJECTED || out_item.kind == KIND_EMPTY
		|| out_item.kind == KIND_ACCEPTED || out_item.kind == KIND_NOT_FOUND) |-> out_item.last)
		else $error("single-result kind without last");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_EMPTY |-> out_item.tag_out == 16'd0)
		else $error("empty notice carries a tag");
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while result pending");
endmodule

bind sorted_countdown_timer_list sctl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_item(in_item), .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);
`default_nettype wire
